@@ sv/ivt_pkg.sv @@
package ivt_pkg;

   // default sizing of the table
   localparam int CAPACITY_DEF      = 256;
   localparam int ELEMENT_WIDTH_DEF = 32;

   // request actions
   localparam logic [2:0] ACT_APPEND = 3'd0;
   localparam logic [2:0] ACT_GET    = 3'd1;
   localparam logic [2:0] ACT_SET    = 3'd2;
   localparam logic [2:0] ACT_DELETE = 3'd3;
   localparam logic [2:0] ACT_INSERT = 3'd4;
   localparam logic [2:0] ACT_FIND   = 3'd5;
   localparam logic [2:0] ACT_COUNT  = 3'd6;
   localparam logic [2:0] ACT_CLEAR  = 3'd7;

   // response status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  entry_index;
      logic [31:0] element_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  position;
      logic [31:0] read_value;
      logic [8:0]  match_count;
      logic [8:0]  table_length;
   } rsp_type;

endpackage

@@ sv/indexed_vector_table.sv @@
// sequencing: append, set, clear and rejected requests go from idle straight to the done state;
// get, find, count, delete and insert first pass through the scan state, which walks the
// entries through the single memory read port; the done state then loads the response.
// throughput: one transaction at a time; a new request is taken once the previous response
// is loaded into the output register, which may still wait on rsp_stall.
// reset: clears the length, the sequencer and the response valid; table contents are kept.
module indexed_vector_table #(
   parameter int CAPACITY      = ivt_pkg::CAPACITY_DEF,
   parameter int ELEMENT_WIDTH = ivt_pkg::ELEMENT_WIDTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ivt_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output ivt_pkg::rsp_type rsp_data
);
   import ivt_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 8) ? CW : 8;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // entry memory
   logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];
   logic [ELEMENT_WIDTH-1:0] rdata_ff;
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [ELEMENT_WIDTH-1:0] mem_wdata;
   logic                     mem_re;
   logic [AW-1:0]            mem_raddr;

   // control and working registers
   logic [1:0]               state_ff, state_in;
   logic [2:0]               act_ff, act_in;
   logic [7:0]               idx_ff, idx_in;
   logic [ELEMENT_WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0]            ptr_ff, ptr_in;
   logic [CW-1:0]            end_ff, end_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [1:0]               status_ff, status_in;
   logic [CW-1:0]            pos_ff, pos_in;
   logic [ELEMENT_WIDTH-1:0] rdv_ff, rdv_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     pv_ff, pv_in;
   logic [CW-1:0]            pa_ff, pa_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     issue;
   logic                     match;
   logic                     full;
   logic [CW-1:0]            ptr_m1;
   logic [XW-1:0]            req_idx_x;
   logic [XW-1:0]            count_x;
   logic [ELEMENT_WIDTH-1:0] req_elem;

   assign match     = (rdata_ff == val_ff);
   assign full      = (count_ff >= CW'(CAPACITY));
   assign ptr_m1    = ptr_ff - 1'b1;
   assign req_idx_x = XW'(req_data.entry_index);
   assign count_x   = XW'(count_ff);
   assign req_elem  = ELEMENT_WIDTH'(req_data.element_value);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      rdv_in       = rdv_ff;
      cnt_in       = cnt_ff;
      pv_in        = 1'b0;
      pa_in        = pa_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[AW-1:0];
      mem_wdata    = val_ff;
      mem_re       = 1'b0;
      mem_raddr    = ptr_ff[AW-1:0];
      issue        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in    = req_data.action;
               idx_in    = req_data.entry_index;
               val_in    = req_elem;
               status_in = STATUS_OK;
               pos_in    = '0;
               rdv_in    = '0;
               cnt_in    = '0;
               state_in  = ST_DONE;
               case (req_data.action)
                  ACT_APPEND: begin
                     if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = req_elem;
                        pos_in    = count_ff;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  ACT_GET: begin
                     if (req_idx_x < count_x) begin
                        ptr_in   = CW'(req_data.entry_index);
                        end_in   = CW'(req_data.entry_index) + 1'b1;
                        state_in = ST_SCAN;
                     end else begin
                        status_in = STATUS_MISS;
                     end
                  end
                  ACT_SET: begin
                     if (req_idx_x < count_x) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(req_data.entry_index);
                        mem_wdata = req_elem;
                     end else begin
                        status_in = STATUS_MISS;
                     end
                  end
                  ACT_DELETE: begin
                     if (req_idx_x < count_x) begin
                        ptr_in   = CW'(req_data.entry_index) + 1'b1;
                        end_in   = count_ff;
                        state_in = ST_SCAN;
                     end else begin
                        status_in = STATUS_MISS;
                     end
                  end
                  ACT_INSERT: begin
                     if (req_idx_x > count_x) begin
                        status_in = STATUS_MISS;
                     end else if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ptr_in   = count_ff;
                        state_in = ST_SCAN;
                     end
                  end
                  ACT_FIND: begin
                     status_in = STATUS_MISS;
                     ptr_in    = '0;
                     end_in    = count_ff;
                     state_in  = ST_SCAN;
                  end
                  ACT_COUNT: begin
                     ptr_in   = '0;
                     end_in   = count_ff;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     // clear
                     cnt_in   = count_ff;
                     count_in = '0;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // issue the next read: insert walks down, all others walk up
            if (act_ff == ACT_INSERT) begin
               issue     = (XW'(ptr_ff) > XW'(idx_ff));
               mem_raddr = ptr_m1[AW-1:0];
               if (issue) begin
                  ptr_in = ptr_m1;
                  pa_in  = ptr_m1;
               end
            end else begin
               issue     = (ptr_ff < end_ff) &&
                           !((act_ff == ACT_FIND) && (status_ff == STATUS_OK));
               mem_raddr = ptr_ff[AW-1:0];
               if (issue) begin
                  ptr_in = ptr_ff + 1'b1;
                  pa_in  = ptr_ff;
               end
            end
            mem_re = issue;
            pv_in  = issue;

            // consume the entry read in the previous cycle
            if (pv_ff) begin
               case (act_ff)
                  ACT_GET: begin
                     rdv_in = rdata_ff;
                  end
                  ACT_DELETE: begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(pa_ff - 1'b1);
                     mem_wdata = rdata_ff;
                  end
                  ACT_INSERT: begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(pa_ff + 1'b1);
                     mem_wdata = rdata_ff;
                  end
                  ACT_FIND: begin
                     if (match && (status_ff != STATUS_OK)) begin
                        status_in = STATUS_OK;
                        pos_in    = pa_ff;
                     end
                  end
                  ACT_COUNT: begin
                     if (match) begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end

            // walk finished
            if (!issue && !pv_ff) begin
               state_in = ST_DONE;
               if (act_ff == ACT_DELETE) begin
                  count_in = count_ff - 1'b1;
               end else if (act_ff == ACT_INSERT) begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(idx_ff);
                  mem_wdata = val_ff;
                  count_in  = count_ff + 1'b1;
               end
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status       = status_ff;
               rsp_in.position     = 8'(pos_ff);
               rsp_in.read_value   = 32'(rdv_ff);
               rsp_in.match_count  = 9'(cnt_ff);
               rsp_in.table_length = 9'(count_ff);
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and response registers
   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      ptr_ff    <= ptr_in;
      end_ff    <= end_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      rdv_ff    <= rdv_in;
      cnt_ff    <= cnt_in;
      pa_ff     <= pa_in;
      rsp_ff    <= rsp_in;
   end

endmodule

@@ sv/ivt_checker.sv @@
module ivt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input ivt_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ivt_pkg::rsp_type rsp_data
);
   import ivt_pkg::*;

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK) || (rsp_data.status == STATUS_MISS) ||
                    (rsp_data.status == STATUS_FULL))
      else $error("undefined response status");

   // a failed transaction reports no position, data or count
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |->
         (rsp_data.position == 8'd0) && (rsp_data.read_value == 32'd0) &&
         (rsp_data.match_count == 9'd0))
      else $error("failed transaction carries nonzero result fields");

   // the block is busy right after taking a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while busy");

   // a stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind indexed_vector_table ivt_checker u_ivt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ dv/indexed_vector_table_tb.sv @@
`timescale 1ns / 1ps

module indexed_vector_table_tb;
   import ivt_pkg::*;

   localparam int TABLE_CAP  = CAPACITY_DEF;
   localparam int LONG_HOLD  = 300;
   localparam int PHASE_REQS = 633;
   localparam int MAX_PRINTS = 100;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // stimulus waiting to be offered, results waiting to arrive
   req_type     pend_reqs[$];
   rsp_type     expected_rsps[$];

   // shadow of the table contents and length
   logic [31:0] shadow_tbl [TABLE_CAP];
   int unsigned shadow_len = 0;

   // length as the generator sees it when building sequences
   int unsigned gen_len = 0;
   int          phase_reqs = 0;

   int          sender_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic        hold_arm = 1'b0;
   int          hold_left = 0;
   int          mismatch_count = 0;
   int          rsp_seen = 0;

   logic [31:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                   32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                                   32'h1234_5678, 32'h0F0F_F0F0};

   indexed_vector_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // apply one transaction to the shadow table and return its response
   function automatic rsp_type run_table_op(req_type r);
      rsp_type     res;
      int unsigned i;
      res = '0;
      res.status = STATUS_OK;
      case (r.action)
         ACT_APPEND: begin
            if (shadow_len >= TABLE_CAP) begin
               res.status = STATUS_FULL;
            end else begin
               shadow_tbl[shadow_len] = r.element_value;
               res.position = shadow_len[7:0];
               shadow_len++;
            end
         end
         ACT_GET: begin
            if (r.entry_index < shadow_len) res.read_value = shadow_tbl[r.entry_index];
            else res.status = STATUS_MISS;
         end
         ACT_SET: begin
            if (r.entry_index < shadow_len) shadow_tbl[r.entry_index] = r.element_value;
            else res.status = STATUS_MISS;
         end
         ACT_DELETE: begin
            if (r.entry_index < shadow_len) begin
               for (i = r.entry_index; i + 1 < shadow_len; i++)
                  shadow_tbl[i] = shadow_tbl[i + 1];
               shadow_len--;
            end else begin
               res.status = STATUS_MISS;
            end
         end
         ACT_INSERT: begin
            if (r.entry_index > shadow_len) begin
               res.status = STATUS_MISS;
            end else if (shadow_len >= TABLE_CAP) begin
               res.status = STATUS_FULL;
            end else begin
               for (i = shadow_len; i > r.entry_index; i--)
                  shadow_tbl[i] = shadow_tbl[i - 1];
               shadow_tbl[r.entry_index] = r.element_value;
               shadow_len++;
            end
         end
         ACT_FIND: begin
            res.status = STATUS_MISS;
            for (i = 0; i < shadow_len; i++) begin
               if (res.status == STATUS_MISS && shadow_tbl[i] == r.element_value) begin
                  res.position = i[7:0];
                  res.status = STATUS_OK;
               end
            end
         end
         ACT_COUNT: begin
            for (i = 0; i < shadow_len; i++)
               if (shadow_tbl[i] == r.element_value) res.match_count++;
         end
         default: begin
            res.match_count = shadow_len[8:0];
            shadow_len = 0;
         end
      endcase
      res.table_length = shadow_len[8:0];
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < MAX_PRINTS)
         $display("response %0d: %s got %0h want %0h", rsp_seen, field, got, want);
      mismatch_count++;
   endtask

   // queue one transaction and track the length it leaves behind
   task automatic queue_item(logic [2:0] act, logic [7:0] idx, logic [31:0] val);
      req_type r;
      r.action = act;
      r.entry_index = idx;
      r.element_value = val;
      pend_reqs.push_back(r);
      phase_reqs++;
      case (act)
         ACT_APPEND: if (gen_len < TABLE_CAP) gen_len++;
         ACT_DELETE: if (idx < gen_len) gen_len--;
         ACT_INSERT: if (idx <= gen_len && gen_len < TABLE_CAP) gen_len++;
         ACT_CLEAR:  gen_len = 0;
         default: ;
      endcase
   endtask

   // random index and value, mostly within the live part of the table
   task automatic queue_random(logic [2:0] act);
      int          pick;
      int unsigned top;
      logic [7:0]  idx;
      logic [31:0] val;
      top = (gen_len > 255) ? 255 : gen_len;
      pick = $urandom_range(0, 9);
      if (pick < 7) idx = 8'($urandom_range(0, top));
      else if (pick == 7) idx = (gen_len > 0) ? 8'(top - 1) : 8'd0;
      else idx = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) < 6) val = value_pool[$urandom_range(0, 7)];
      else val = $urandom;
      queue_item(act, idx, val);
   endtask

   // one well-formed sequence: optionally fill to capacity, then mixed traffic
   task automatic queue_episode();
      int         n;
      int         pick;
      logic [2:0] act;
      if ($urandom_range(0, 9) == 0) begin
         while (gen_len < TABLE_CAP) queue_random(ACT_APPEND);
         n = $urandom_range(10, 25);
      end else begin
         if ($urandom_range(0, 3) == 0) queue_random(ACT_CLEAR);
         n = $urandom_range(10, 40);
      end
      repeat (n) begin
         pick = $urandom_range(0, 31);
         if (pick < 7) act = ACT_APPEND;
         else if (pick < 11) act = ACT_GET;
         else if (pick < 15) act = ACT_SET;
         else if (pick < 19) act = ACT_DELETE;
         else if (pick < 24) act = ACT_INSERT;
         else if (pick < 28) act = ACT_FIND;
         else if (pick < 31) act = ACT_COUNT;
         else act = ACT_CLEAR;
         queue_random(act);
      end
   endtask

   task automatic wait_drained();
      while (pend_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
         @(negedge clock);
   endtask

   // driver: offer queued transactions, predict each one as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) expected_rsps.push_back(run_table_op(req_data));
         if (pend_reqs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_data <= pend_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall: random, or one long hold-off when armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_arm && hold_left == 0) begin
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // monitor: compare every accepted response with the oldest prediction
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response, status", 32'(rsp_data.status), 32'd0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.position !== want.position)
               report_mismatch("position", 32'(rsp_data.position), 32'(want.position));
            if (rsp_data.read_value !== want.read_value)
               report_mismatch("read_value", rsp_data.read_value, want.read_value);
            if (rsp_data.match_count !== want.match_count)
               report_mismatch("match_count", 32'(rsp_data.match_count),
                               32'(want.match_count));
            if (rsp_data.table_length !== want.table_length)
               report_mismatch("table_length", 32'(rsp_data.table_length),
                               32'(want.table_length));
         end
         rsp_seen++;
      end
   end

   // stimulus and end of test
   initial begin
      int ph;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table corner cases, then edits on a short table
      queue_item(ACT_FIND,   8'd0,   32'h0000_0000);
      queue_item(ACT_COUNT,  8'd0,   32'h0000_0000);
      queue_item(ACT_CLEAR,  8'd0,   32'h0000_0000);
      queue_item(ACT_GET,    8'd0,   32'h0000_0000);
      queue_item(ACT_SET,    8'd0,   32'hFFFF_FFFF);
      queue_item(ACT_DELETE, 8'd0,   32'h0000_0000);
      queue_item(ACT_INSERT, 8'd1,   32'h1111_1111);
      queue_item(ACT_INSERT, 8'd0,   32'hFFFF_FFFF);
      queue_item(ACT_APPEND, 8'd255, 32'h0000_0000);
      queue_item(ACT_APPEND, 8'd0,   32'hA5A5_A5A5);
      queue_item(ACT_INSERT, 8'd1,   32'h5A5A_5A5A);
      queue_item(ACT_INSERT, 8'd4,   32'h7777_7777);
      queue_item(ACT_GET,    8'd0,   32'h0000_0000);
      queue_item(ACT_GET,    8'd3,   32'hFFFF_FFFF);
      queue_item(ACT_GET,    8'd4,   32'h0000_0000);
      queue_item(ACT_GET,    8'd255, 32'h0000_0000);
      queue_item(ACT_SET,    8'd2,   32'hFFFF_FFFF);
      queue_item(ACT_FIND,   8'd0,   32'hFFFF_FFFF);
      queue_item(ACT_COUNT,  8'd0,   32'hFFFF_FFFF);
      queue_item(ACT_FIND,   8'd0,   32'h1234_5678);
      queue_item(ACT_DELETE, 8'd0,   32'h0000_0000);
      queue_item(ACT_DELETE, 8'd3,   32'h0000_0000);
      queue_item(ACT_DELETE, 8'd255, 32'h0000_0000);
      queue_item(ACT_CLEAR,  8'd0,   32'h0000_0000);
      wait_drained();

      // three traffic phases with different idle patterns
      for (ph = 0; ph < 3; ph++) begin
         sender_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 67 : 0;
         recv_stall_pct  = (ph == 0) ? 67 : (ph == 1) ? 8 : 0;
         phase_reqs = 0;
         while (phase_reqs < PHASE_REQS) queue_episode();
         if (ph == 2) begin
            // long response hold-off while requests keep coming
            hold_arm = 1'b1;
            @(negedge clock);
            hold_arm = 1'b0;
         end
         wait_drained();
      end

      repeat (TABLE_CAP + 10) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0)
         $display("indexed_vector_table: match");
      else
         $display("indexed_vector_table: mismatch");
      $finish;
   end

   initial begin
      #(30_000_000);
      $display("indexed_vector_table: mismatch");
      $finish;
   end

endmodule

@@ indexed_vector_table.f @@
sv/ivt_pkg.sv
sv/indexed_vector_table.sv
sv/ivt_checker.sv
dv/indexed_vector_table_tb.sv
